/* src/hpa_pkg.sv */
package hpa_pkg;

  localparam int HANDLE_W = 8;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_TRY     = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // free queue control from the request logic
  typedef struct packed {
    logic    push;
    logic    pop;
    handle_t push_data;
  } fq_ctrl_t;

  // free queue status back to the request logic
  typedef struct packed {
    logic    empty;
    handle_t head_data;
  } fq_stat_t;

endpackage

/* src/hpa_free_queue.sv */
module hpa_free_queue
  import hpa_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  fq_ctrl_t ctrl,
  output fq_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  handle_t        mem [DEPTH];
  handle_t        rd_data;
  logic [AW-1:0]  head;
  logic [AW-1:0]  head_next;
  logic [AW-1:0]  tail;
  logic [AW-1:0]  tail_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctrl.pop) begin
      head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      count_next = count - CW'(1);
    end
    if (ctrl.push) begin
      tail_next  = (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // rd_data always holds the entry at head; a push into that slot bypasses
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= ctrl.push_data;
    end
    if (ctrl.push && (tail == head_next)) begin
      rd_data <= ctrl.push_data;
    end else begin
      rd_data <= mem[head_next];
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.head_data = rd_data;

endmodule

/* src/handle_pool_allocator_core.sv */
// Channel | Direction | Handshake             | Payload
// req     | in        | in_valid / in_stall   | req_type, release_handle
// rsp     | out       | out_valid / out_stall | granted_handle, status
//
// One request per cycle while in_stall is low; its response is registered on accept.
// The free queue keeps the entry at its head prefetched in a read register,
// so a pop need not wait for a memory read.
// Synchronous reset clears the in-use bitmap, counters and queue pointers at once.
// in_stall is high during reset and while a response is held and out_stall is high.
module handle_pool_allocator_core
  import hpa_pkg::*;
#(
  parameter int POOL_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [HANDLE_W-1:0] release_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] granted_handle,
  output logic [1:0]          status
);

  localparam int HW     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int FW     = $clog2(POOL_SIZE + 1);
  localparam int QDEPTH = (POOL_SIZE < 2 ** HANDLE_W) ? POOL_SIZE : 2 ** HANDLE_W;

  logic                 acc;
  logic [POOL_SIZE-1:0] in_use;
  logic [FW-1:0]        fresh;
  logic                 fresh_inc;
  logic                 rel_in_range;
  logic [HW-1:0]        rel_idx;
  logic [HW-1:0]        map_idx;
  logic                 map_wr;
  logic                 map_val;
  handle_t              grant_next;
  status_t              st_next;
  fq_ctrl_t             q_ctrl;
  fq_stat_t             q_stat;

  assign in_stall     = rst || (out_valid && out_stall);
  assign acc          = in_valid && !in_stall;
  assign rel_in_range = 32'(release_handle) < POOL_SIZE;
  assign rel_idx      = HW'(32'(release_handle));

  hpa_free_queue #(
    .DEPTH (QDEPTH)
  ) u_free_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  always_comb begin
    q_ctrl     = '0;
    grant_next = '0;
    st_next    = ST_OK;
    map_idx    = rel_idx;
    map_wr     = 1'b0;
    map_val    = 1'b0;
    fresh_inc  = 1'b0;
    case (req_t'(req_type))
      REQ_ALLOC, REQ_TRY: begin
        if (!q_stat.empty) begin
          q_ctrl.pop = acc;
          grant_next = q_stat.head_data;
          map_idx    = HW'(32'(q_stat.head_data));
          map_wr     = acc;
          map_val    = 1'b1;
        end else if (req_t'(req_type) == REQ_TRY) begin
          st_next = ST_NONE_FREE;
        end else if (fresh != FW'(POOL_SIZE)) begin
          grant_next = HANDLE_W'(32'(fresh));
          map_idx    = HW'(fresh);
          map_wr     = acc;
          map_val    = 1'b1;
          fresh_inc  = acc;
        end else begin
          st_next = ST_EXHAUSTED;
        end
      end
      REQ_RELEASE: begin
        if (!rel_in_range || !in_use[rel_idx]) begin
          st_next = ST_UNKNOWN;
        end else begin
          map_wr           = acc;
          q_ctrl.push      = acc;
          q_ctrl.push_data = release_handle;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      fresh  <= '0;
    end else begin
      if (map_wr) begin
        in_use[map_idx] <= map_val;
      end
      if (fresh_inc) begin
        fresh <= fresh + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      granted_handle <= grant_next;
      status         <= st_next;
    end
  end

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= FW'(POOL_SIZE))
    else $error("fresh counter past pool size");

  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    (map_wr && map_val) |=> in_use[$past(map_idx)])
    else $error("granted handle not marked in use");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (q_ctrl.push) |=> !in_use[$past(map_idx)] && !q_stat.empty)
    else $error("released handle still marked or queue empty");

  a_try_empty: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type == REQ_TRY && q_stat.empty) |=> status == ST_NONE_FREE)
    else $error("try on empty queue did not report none free");

endmodule
